FILE: sv/npsched_pkg.sv
// Shared types and constants for the nonpreemptive priority scheduler.
`default_nettype none

package npsched_pkg;

   localparam int BURST_W = 8;
   localparam int PRIO_W = 8;
   localparam int ARR_W = 10;
   localparam int TIME_W = 16;
   localparam int CLK_W = 17;
   localparam int PIDX_W = 4;
   localparam logic [TIME_W-1:0] TIME_LIMIT_RESET = 16'd1000;

   typedef struct packed {
      logic [BURST_W-1:0] burst_time;
      logic [PRIO_W-1:0]  priority_req;
      logic [ARR_W-1:0]   arrival_time;
      logic               last_process;
   } req_word_type;

   typedef struct packed {
      logic [PIDX_W-1:0] process_index;
      logic              was_scheduled;
      logic [TIME_W-1:0] waiting_time;
      logic [TIME_W-1:0] turnaround_time;
      logic [TIME_W-1:0] average_waiting;
      logic [TIME_W-1:0] average_turnaround;
      logic              last_result;
   } rsp_word_type;

   typedef struct packed {
      logic [BURST_W-1:0] burst;
      logic [PRIO_W-1:0]  prio;
      logic [ARR_W-1:0]   arrival;
   } proc_entry_type;

   typedef struct packed {
      logic [TIME_W-1:0] waiting;
      logic [TIME_W-1:0] turnaround;
   } result_entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_CHECK,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE,
      ST_COMMIT,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_OUT_READ,
      ST_OUT_SEND
   } sched_state_type;

   typedef struct packed {
      logic load;
      logic init_run;
      logic scan_clear;
      logic scan_issue;
      logic decide;
      logic commit;
      logic div_start;
      logic out_clear;
      logic out_read;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic run_over;
      logic idx_last;
      logic found;
      logic div_busy;
      logic out_last;
   } ctrl_stat_type;

endpackage

`default_nettype wire

FILE: sv/nonpreemptive_priority_scheduler.sv
// Top level of the nonpreemptive priority scheduler.
// Words on req_ are stored one per cycle (a word arriving with the table full
// is dropped); a word with last_process set closes the set and starts the
// run, and req_ready stays low until every result of that run has been taken.
// Each scheduling decision scans the stored table through a one-port memory,
// one entry per cycle; when nothing has arrived, the clock jumps straight to
// the next arrival or past time_limit. The two averages then come from a
// shared restoring divider. Results leave in index order; each word is read
// from the result store and held until rsp_ready takes it. csr_wr_data sets
// time_limit (reset 1000) and should only be written between runs.
`default_nettype none

module nonpreemptive_priority_scheduler
   import npsched_pkg::*;
#(
   parameter int MAX_PROCESSES = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire req_word_type      req_word,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rsp_word_type           rsp_word,
   input  wire logic              csr_wr_en,
   input  wire logic [TIME_W-1:0] csr_wr_data
);

   localparam int CNT_W = $clog2(MAX_PROCESSES + 1);
   localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
   localparam int SUM_W = TIME_W + CNT_W;

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   npsched_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_word.last_process),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   npsched_datapath #(
      .MAX_PROCESSES(MAX_PROCESSES),
      .CNT_W        (CNT_W),
      .IDX_W        (IDX_W),
      .SUM_W        (SUM_W)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_word    (req_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .stat        (stat),
      .rsp_word    (rsp_word)
   );

endmodule

`default_nettype wire

FILE: sv/npsched_div.sv
// Two-lane restoring divider sharing one divisor, one quotient bit per cycle.
`default_nettype none

module npsched_div
   import npsched_pkg::*;
#(
   parameter int CNT_W = 5,
   parameter int SUM_W = 21
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [CNT_W-1:0]  divisor,
   input  wire logic [SUM_W-1:0]  dividend_a,
   input  wire logic [SUM_W-1:0]  dividend_b,
   output logic                   busy,
   output logic [TIME_W-1:0]      quot_a,
   output logic [TIME_W-1:0]      quot_b
);

   localparam int STEP_W = $clog2(SUM_W);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

   logic              busy_ff;
   logic [STEP_W-1:0] step_ff;
   logic [CNT_W-1:0]  dsr_ff;
   logic [CNT_W-1:0]  rem_a_ff, rem_b_ff;
   logic [SUM_W-1:0]  quo_a_ff, quo_b_ff;

   logic [CNT_W:0]    trial_a, trial_b;
   logic              ge_a, ge_b;
   logic [CNT_W:0]    diff_a, diff_b;
   logic [CNT_W-1:0]  rem_a_in, rem_b_in;

   always_comb begin
      trial_a = {rem_a_ff, quo_a_ff[SUM_W-1]};
      trial_b = {rem_b_ff, quo_b_ff[SUM_W-1]};
      ge_a = trial_a >= {1'b0, dsr_ff};
      ge_b = trial_b >= {1'b0, dsr_ff};
      diff_a = trial_a - {1'b0, dsr_ff};
      diff_b = trial_b - {1'b0, dsr_ff};
      rem_a_in = ge_a ? diff_a[CNT_W-1:0] : trial_a[CNT_W-1:0];
      rem_b_in = ge_b ? diff_b[CNT_W-1:0] : trial_b[CNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && step_ff == STEP_LAST) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         step_ff  <= '0;
         dsr_ff   <= divisor;
         rem_a_ff <= '0;
         rem_b_ff <= '0;
         quo_a_ff <= dividend_a;
         quo_b_ff <= dividend_b;
      end else if (busy_ff) begin
         step_ff  <= step_ff + STEP_W'(1);
         rem_a_ff <= rem_a_in;
         rem_b_ff <= rem_b_in;
         quo_a_ff <= {quo_a_ff[SUM_W-2:0], ge_a};
         quo_b_ff <= {quo_b_ff[SUM_W-2:0], ge_b};
      end
   end

   assign busy = busy_ff;
   assign quot_a = (|quo_a_ff[SUM_W-1:TIME_W]) ? '1 : quo_a_ff[TIME_W-1:0];
   assign quot_b = (|quo_b_ff[SUM_W-1:TIME_W]) ? '1 : quo_b_ff[TIME_W-1:0];

endmodule

`default_nettype wire

FILE: sv/npsched_datapath.sv
// Process tables, selection scan, schedule clock, result store and averages.
`default_nettype none

module npsched_datapath
   import npsched_pkg::*;
#(
   parameter int MAX_PROCESSES = 16,
   parameter int CNT_W = 5,
   parameter int IDX_W = 4,
   parameter int SUM_W = 21
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ctrl_cmd_type      cmd,
   input  wire req_word_type      req_word,
   input  wire logic              csr_wr_en,
   input  wire logic [TIME_W-1:0] csr_wr_data,
   output ctrl_stat_type          stat,
   output rsp_word_type           rsp_word
);

   function automatic logic [TIME_W-1:0] sat16(input logic [CLK_W-1:0] v);
      sat16 = v[CLK_W-1] ? '1 : v[TIME_W-1:0];
   endfunction

   proc_entry_type   proc_mem [MAX_PROCESSES];
   result_entry_type res_mem  [MAX_PROCESSES];

   logic [CNT_W-1:0]         count_ff;
   logic [TIME_W-1:0]        limit_ff;
   logic [IDX_W-1:0]         idx_ff;
   logic [IDX_W-1:0]         rd_idx_ff;
   logic                     rd_vld_ff;
   proc_entry_type           proc_rd_ff;
   result_entry_type         res_rd_ff;
   logic [MAX_PROCESSES-1:0] done_ff;
   logic [CLK_W-1:0]         clk_ff;
   logic [CNT_W-1:0]         left_ff;
   logic                     found_ff;
   logic [IDX_W-1:0]         best_idx_ff;
   logic [PRIO_W-1:0]        best_prio_ff;
   logic [BURST_W-1:0]       best_burst_ff;
   logic [ARR_W-1:0]         best_arr_ff;
   logic [ARR_W-1:0]         min_arr_ff;
   logic [TIME_W-1:0]        wait_ff, turn_ff;
   logic [SUM_W-1:0]         sum_w_ff, sum_t_ff;
   logic                     out_last_ff;

   logic [CLK_W-1:0]   arr_ext, lim_plus, min_arr_ext;
   logic               rd_done, eligible, better;
   logic [CLK_W-1:0]   wait_raw, turn_raw, clk_in;
   logic               idx_last;
   logic               div_busy;
   logic [TIME_W-1:0]  avg_w, avg_t;
   logic [IDX_W+3:0]   pidx_ext;

   // CSR
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= TIME_LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   // load side; a full table drops the word
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.finish) begin
         count_ff <= '0;
      end else if (cmd.load && count_ff < CNT_W'(MAX_PROCESSES)) begin
         count_ff <= count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && count_ff < CNT_W'(MAX_PROCESSES)) begin
         proc_mem[count_ff[IDX_W-1:0]] <= '{burst:   req_word.burst_time,
                                            prio:    req_word.priority_req,
                                            arrival: req_word.arrival_time};
      end
      if (cmd.scan_issue) begin
         proc_rd_ff <= proc_mem[idx_ff];
      end
   end

   assign idx_last = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;

   // shared address counter for scan and output
   always_ff @(posedge clock) begin
      if (cmd.scan_clear || cmd.out_clear) begin
         idx_ff <= '0;
      end else if (cmd.scan_issue || cmd.out_read) begin
         idx_ff <= idx_ff + IDX_W'(1);
      end
      if (cmd.scan_issue || cmd.out_read) begin
         rd_idx_ff <= idx_ff;
      end
      if (cmd.out_read) begin
         out_last_ff <= idx_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.scan_issue;
      end
   end

   // selection compare, one entry per cycle
   always_comb begin
      rd_done  = done_ff[rd_idx_ff];
      arr_ext  = CLK_W'(proc_rd_ff.arrival);
      eligible = !rd_done && arr_ext <= clk_ff;
      better   = !found_ff || proc_rd_ff.prio < best_prio_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_clear) begin
         found_ff   <= 1'b0;
         min_arr_ff <= '1;
      end else if (rd_vld_ff) begin
         if (eligible && better) begin
            found_ff      <= 1'b1;
            best_idx_ff   <= rd_idx_ff;
            best_prio_ff  <= proc_rd_ff.prio;
            best_burst_ff <= proc_rd_ff.burst;
            best_arr_ff   <= proc_rd_ff.arrival;
         end
         if (!rd_done && proc_rd_ff.arrival < min_arr_ff) begin
            min_arr_ff <= proc_rd_ff.arrival;
         end
      end
   end

   // decision: run the pick, or jump the clock to the next arrival
   always_comb begin
      wait_raw    = clk_ff - CLK_W'(best_arr_ff);
      turn_raw    = wait_raw + CLK_W'(best_burst_ff);
      lim_plus    = CLK_W'(limit_ff) + CLK_W'(1);
      min_arr_ext = CLK_W'(min_arr_ff);
      if (found_ff) begin
         clk_in = clk_ff + CLK_W'(best_burst_ff);
      end else begin
         clk_in = (min_arr_ext < lim_plus) ? min_arr_ext : lim_plus;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.init_run) begin
         clk_ff   <= '0;
         left_ff  <= count_ff;
         sum_w_ff <= '0;
         sum_t_ff <= '0;
      end else if (cmd.decide) begin
         clk_ff  <= clk_in;
         wait_ff <= sat16(wait_raw);
         turn_ff <= sat16(turn_raw);
      end else if (cmd.commit) begin
         left_ff  <= left_ff - CNT_W'(1);
         sum_w_ff <= sum_w_ff + SUM_W'(wait_ff);
         sum_t_ff <= sum_t_ff + SUM_W'(turn_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= '0;
      end else if (cmd.init_run) begin
         done_ff <= '0;
      end else if (cmd.commit) begin
         done_ff[best_idx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         res_mem[best_idx_ff] <= '{waiting: wait_ff, turnaround: turn_ff};
      end
      if (cmd.out_read) begin
         res_rd_ff <= res_mem[idx_ff];
      end
   end

   npsched_div #(
      .CNT_W(CNT_W),
      .SUM_W(SUM_W)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (cmd.div_start),
      .divisor    (count_ff),
      .dividend_a (sum_w_ff),
      .dividend_b (sum_t_ff),
      .busy       (div_busy),
      .quot_a     (avg_w),
      .quot_b     (avg_t)
   );

   assign stat.run_over = (left_ff == '0) || (clk_ff > CLK_W'(limit_ff));
   assign stat.idx_last = idx_last;
   assign stat.found    = found_ff;
   assign stat.div_busy = div_busy;
   assign stat.out_last = out_last_ff;

   // unscheduled entries were never written this run; mask them to zero
   assign pidx_ext = {4'b0, rd_idx_ff};

   always_comb begin
      rsp_word.process_index      = pidx_ext[PIDX_W-1:0];
      rsp_word.was_scheduled      = rd_done;
      rsp_word.waiting_time       = rd_done ? res_rd_ff.waiting : '0;
      rsp_word.turnaround_time    = rd_done ? res_rd_ff.turnaround : '0;
      rsp_word.average_waiting    = out_last_ff ? avg_w : '0;
      rsp_word.average_turnaround = out_last_ff ? avg_t : '0;
      rsp_word.last_result        = out_last_ff;
   end

endmodule

`default_nettype wire

FILE: sv/npsched_ctrl.sv
// Sequencer for load, scheduling decisions, averaging and result output.
`default_nettype none

module npsched_ctrl
   import npsched_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          req_last,
   input  wire logic          rsp_ready,
   input  wire ctrl_stat_type stat,
   output logic               req_ready,
   output logic               rsp_valid,
   output ctrl_cmd_type       cmd
);

   sched_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_last) state_in = ST_START;
         end
         ST_START:     state_in = ST_CHECK;
         ST_CHECK:     state_in = stat.run_over ? ST_DIV_START : ST_SCAN;
         ST_SCAN: begin
            if (stat.idx_last) state_in = ST_DRAIN;
         end
         ST_DRAIN:     state_in = ST_DECIDE;
         ST_DECIDE:    state_in = stat.found ? ST_COMMIT : ST_CHECK;
         ST_COMMIT:    state_in = ST_CHECK;
         ST_DIV_START: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (!stat.div_busy) state_in = ST_OUT_READ;
         end
         ST_OUT_READ:  state_in = ST_OUT_SEND;
         ST_OUT_SEND: begin
            if (rsp_ready) state_in = stat.out_last ? ST_IDLE : ST_OUT_READ;
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_START:  cmd.init_run = 1'b1;
         ST_CHECK:  cmd.scan_clear = 1'b1;
         ST_SCAN:   cmd.scan_issue = 1'b1;
         ST_DRAIN:  ;
         ST_DECIDE: cmd.decide = 1'b1;
         ST_COMMIT: cmd.commit = 1'b1;
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            cmd.out_clear = 1'b1;
         end
         ST_DIV_WAIT: ;
         ST_OUT_READ: cmd.out_read = 1'b1;
         ST_OUT_SEND: begin
            rsp_valid  = 1'b1;
            cmd.finish = rsp_ready && stat.out_last;
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

FILE: sv/npsched_checker.sv
// Port-level checks for the scheduler, bound to the top level.
`default_nettype none

module npsched_checker
   import npsched_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_ready,
   input wire logic         rsp_valid,
   input wire logic         rsp_ready,
   input wire rsp_word_type rsp_word
);

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   // input is closed while a run delivers its results
   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input open while results pending");

   // averages appear only on the last word of a run
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.last_result |->
         rsp_word.average_waiting == '0 && rsp_word.average_turnaround == '0)
      else $error("averages on a non-final word");

   // an unscheduled process reports zero times
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.was_scheduled |->
         rsp_word.waiting_time == '0 && rsp_word.turnaround_time == '0)
      else $error("nonzero times on an unscheduled process");

   // turnaround includes the wait
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.turnaround_time >= rsp_word.waiting_time)
      else $error("turnaround below waiting time");

endmodule

bind nonpreemptive_priority_scheduler npsched_checker u_npsched_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);

`default_nettype wire

FILE: tb/sv/tb_nonpreemptive_priority_scheduler.sv
// Self-checking testbench for the nonpreemptive priority scheduler.
`timescale 1ns / 1ps

module tb_nonpreemptive_priority_scheduler;
   import npsched_pkg::*;

   localparam int MAX_PROCS     = 16;
   localparam int SETTLE_CYCLES = 64;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int RANDOM_ITEMS  = 350;
   localparam int NUM_PHASES    = 5;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_ready;
   req_word_type      req_word    = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   rsp_word_type      rsp_word;
   logic              csr_wr_en   = 1'b0;
   logic [TIME_W-1:0] csr_wr_data = '0;

   int unsigned cycle_count   = 0;
   int unsigned burst_left    = 0;
   bit          sender_steady = 1'b0;
   int unsigned rx_mode       = 0;
   int unsigned rx_mode_left  = 0;
   int unsigned rx_stall      = 0;

   // Holds the process table, predicts each run's per-process times and
   // averages and compares the returned words against them in order.
   class schedule_checker;
      logic [TIME_W-1:0] time_limit;
      proc_entry_type    procs [MAX_PROCS];
      int unsigned       stored;
      rsp_word_type      expected_times_q [$];
      int unsigned       mismatches;

      function new();
         time_limit = TIME_LIMIT_RESET;
         stored     = 0;
         mismatches = 0;
      endfunction

      function int unsigned sat16(int unsigned v);
         return (v > 65535) ? 65535 : v;
      endfunction

      task report_mismatch(string what, int unsigned got, int unsigned want);
         if (mismatches < 40)
            $display("ERROR @%0t: %s got %0d expected %0d", $time, what, got, want);
         mismatches++;
      endtask

      function void run_priority_schedule();
         int unsigned  clk;
         int unsigned  left;
         int unsigned  pick;
         int unsigned  sum_w;
         int unsigned  sum_t;
         bit           found;
         bit           ran    [MAX_PROCS];
         int unsigned  wait_t [MAX_PROCS];
         int unsigned  turn_t [MAX_PROCS];
         rsp_word_type r;
         for (int i = 0; i < MAX_PROCS; i++) begin
            ran[i]    = 1'b0;
            wait_t[i] = 0;
            turn_t[i] = 0;
         end
         clk  = 0;
         left = stored;
         while (left > 0 && clk <= time_limit) begin
            found = 1'b0;
            pick  = 0;
            for (int i = 0; i < stored; i++) begin
               if (!ran[i] && procs[i].arrival <= clk &&
                   (!found || procs[i].prio < procs[pick].prio)) begin
                  found = 1'b1;
                  pick  = i;
               end
            end
            if (!found) begin
               clk++;
            end else begin
               wait_t[pick] = sat16(clk - procs[pick].arrival);
               clk += procs[pick].burst;
               turn_t[pick] = sat16(clk - procs[pick].arrival);
               ran[pick]    = 1'b1;
               left--;
            end
         end
         sum_w = 0;
         sum_t = 0;
         for (int i = 0; i < stored; i++) begin
            sum_w += wait_t[i];
            sum_t += turn_t[i];
         end
         for (int i = 0; i < stored; i++) begin
            r                    = '0;
            r.process_index      = i[PIDX_W-1:0];
            r.was_scheduled      = ran[i];
            r.waiting_time       = wait_t[i][TIME_W-1:0];
            r.turnaround_time    = turn_t[i][TIME_W-1:0];
            r.last_result        = (i == stored - 1);
            if (r.last_result) begin
               r.average_waiting    = TIME_W'(sat16(sum_w / stored));
               r.average_turnaround = TIME_W'(sat16(sum_t / stored));
            end
            expected_times_q.push_back(r);
         end
      endfunction

      function void note_request(req_word_type w);
         if (stored < MAX_PROCS) begin
            procs[stored].burst   = w.burst_time;
            procs[stored].prio    = w.priority_req;
            procs[stored].arrival = w.arrival_time;
            stored++;
         end
         if (w.last_process) begin
            run_priority_schedule();
            stored = 0;
         end
      endfunction

      task check_result(rsp_word_type got);
         rsp_word_type want;
         if (expected_times_q.size() == 0) begin
            report_mismatch("unexpected result word, index", got.process_index, 0);
         end else begin
            want = expected_times_q.pop_front();
            if (got.process_index !== want.process_index)
               report_mismatch("process_index", got.process_index, want.process_index);
            if (got.was_scheduled !== want.was_scheduled)
               report_mismatch("was_scheduled", got.was_scheduled, want.was_scheduled);
            if (got.waiting_time !== want.waiting_time)
               report_mismatch("waiting_time", got.waiting_time, want.waiting_time);
            if (got.turnaround_time !== want.turnaround_time)
               report_mismatch("turnaround_time", got.turnaround_time,
                               want.turnaround_time);
            if (got.average_waiting !== want.average_waiting)
               report_mismatch("average_waiting", got.average_waiting,
                               want.average_waiting);
            if (got.average_turnaround !== want.average_turnaround)
               report_mismatch("average_turnaround", got.average_turnaround,
                               want.average_turnaround);
            if (got.last_result !== want.last_result)
               report_mismatch("last_result", got.last_result, want.last_result);
         end
      endtask
   endclass

   schedule_checker sb;

   nonpreemptive_priority_scheduler #(
      .MAX_PROCESSES(MAX_PROCS)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Result side: check every taken word, then pick the next ready value.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_word);
         if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(16, 96);
         end
         rx_mode_left--;
         case (rx_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: begin
               // long stalls now and then
               if (rx_stall != 0) begin
                  rsp_ready <= 1'b0;
                  rx_stall--;
               end else begin
                  rsp_ready <= 1'b1;
                  if ($urandom_range(0, 7) == 0)
                     rx_stall = $urandom_range(1, 20);
               end
            end
         endcase
      end
   end

   // Called at a rising edge; returns at the edge where the word is taken.
   task automatic send_word(req_word_type w);
      int unsigned gap;
      if (!sender_steady && burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      if (burst_left != 0)
         burst_left--;
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(w);
   endtask

   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (sb.expected_times_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_time_limit(logic [TIME_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.time_limit = value;
   endtask

   function automatic req_word_type make_word(int unsigned burst, int unsigned prio,
                                              int unsigned arrival, bit last);
      req_word_type w;
      w.burst_time   = burst[BURST_W-1:0];
      w.priority_req = prio[PRIO_W-1:0];
      w.arrival_time = arrival[ARR_W-1:0];
      w.last_process = last;
      return w;
   endfunction

   function automatic req_word_type random_word(bit last, int unsigned spread);
      req_word_type w;
      w.burst_time   = BURST_W'(($urandom_range(0, 4) < 2) ? $urandom_range(0, 15)
                                                           : $urandom_range(0, 255));
      w.priority_req = PRIO_W'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                                    : $urandom_range(0, 255));
      w.arrival_time = ARR_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                          : $urandom_range(0, spread));
      w.last_process = last;
      return w;
   endfunction

   initial begin
      logic [TIME_W-1:0] limits [NUM_PHASES];
      int unsigned       phase_items;
      int unsigned       set_size;
      int unsigned       spread;
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero-length job, then one that arrives past the limit
      send_word(make_word(0, 0, 0, 1'b1));
      send_word(make_word(255, 255, 1023, 1'b1));
      // index 0 not yet arrived; 1 and 2 tie on priority; idle ticks before 0
      send_word(make_word(5, 0, 10, 1'b0));
      send_word(make_word(3, 7, 0, 1'b0));
      send_word(make_word(4, 7, 0, 1'b1));
      // overfull set: the closing word is dropped, long bursts hit the limit
      for (int i = 0; i <= MAX_PROCS; i++)
         send_word(make_word(255, (i * 7) % 16, 3 * i, i == MAX_PROCS));
      drain_and_settle();

      limits[0] = 16'hFFFF;
      limits[1] = 16'd0;
      limits[2] = TIME_W'($urandom_range(1, 3000));
      limits[3] = 16'd400;
      limits[4] = TIME_LIMIT_RESET;
      foreach (limits[ph]) begin
         set_time_limit(limits[ph]);
         phase_items = 0;
         while (phase_items < RANDOM_ITEMS / NUM_PHASES) begin
            case ($urandom_range(0, 19))
               0:       set_size = $urandom_range(MAX_PROCS + 1, MAX_PROCS + 4);
               1, 2:    set_size = MAX_PROCS;
               default: set_size = $urandom_range(1, MAX_PROCS);
            endcase
            spread        = (1 << $urandom_range(0, 10)) - 1;
            sender_steady = ($urandom_range(0, 4) == 0);
            for (int i = 0; i < set_size; i++)
               send_word(random_word(i == set_size - 1, spread));
            phase_items += set_size;
         end
         drain_and_settle();
      end

      if (sb.mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
